[src/assert_macros.svh]
// Assertion macros shared by the scale frame decoder RTL.
// Expects i_clk and active-low i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFWC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sfwc_pkg.sv]
// Shared types, constants and decode helpers for the scale frame decoder.
// No dependencies.
package sfwc_pkg;

    localparam int unsigned THRESH_W = 30;
    localparam int unsigned DROP_W   = 40;
    localparam int unsigned BOUND_W  = 42;   // signed threshold minus drop limit
    localparam int unsigned WEIGHT_W = 49;
    localparam int unsigned DELTA_W  = 50;
    localparam int unsigned DIGITS_W = 24;
    localparam int unsigned MAG_W    = 21;   // unsigned six-digit value
    localparam int unsigned VALUE_W  = 22;   // signed six-digit value
    localparam int unsigned FACTOR_W = 28;   // 16 * 10^7 fits
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 64;

    localparam logic [7:0] HEADER_VALUE = 8'hFF;
    localparam int unsigned NEG_BIT     = 5;

    localparam logic [1:0] LINK_FULL  = 2'd0;
    localparam logic [1:0] LINK_SHORT = 2'd1;

    // Register select is address bit 3 (registers sit on 8-byte strides).
    localparam logic REG_CHANGE_THRESHOLD = 1'b0;
    localparam logic REG_DROP_LIMIT       = 1'b1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 30'd100000;
    localparam logic [DROP_W-1:0]   DROP_RESET   = 40'd80000000;

    typedef enum logic [2:0] {
        RES_CHANGE     = 3'd0,
        RES_NO_CHANGE  = 3'd1,
        RES_SHORT_READ = 3'd2,
        RES_READ_ERROR = 3'd3,
        RES_BAD_HEADER = 3'd4
    } t_result_code;

    // 16 * 10^(7-dp)
    function automatic logic [FACTOR_W-1:0] scale_factor(input logic [2:0] dp);
        logic [FACTOR_W-1:0] f;
        case (dp)
            3'd0: f = 28'd160000000;
            3'd1: f = 28'd16000000;
            3'd2: f = 28'd1600000;
            3'd3: f = 28'd160000;
            3'd4: f = 28'd16000;
            3'd5: f = 28'd1600;
            3'd6: f = 28'd160;
            3'd7: f = 28'd16;
            default: f = 28'd16;
        endcase
        return f;
    endfunction

    // Two packed digits; nibbles above 9 are taken at face value.
    function automatic logic [7:0] byte_digits(input logic [7:0] b);
        return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
    endfunction

endpackage

[src/sfwc_if.sv]
// Valid/ready stream interfaces for scale frames and decode results.
// Depends on sfwc_pkg.
interface sfwc_frame_if;
    import sfwc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] link_status;
    logic [7:0] header_byte;
    logic [7:0] status_byte;
    logic [7:0] digits_low_byte;
    logic [7:0] digits_mid_byte;
    logic [7:0] digits_high_byte;

    modport source (output valid, link_status, header_byte, status_byte,
                    digits_low_byte, digits_mid_byte, digits_high_byte,
                    input ready);
    modport sink   (input valid, link_status, header_byte, status_byte,
                    digits_low_byte, digits_mid_byte, digits_high_byte,
                    output ready);
endinterface

interface sfwc_result_if;
    import sfwc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [2:0]                result_code;
    logic signed [DELTA_W-1:0] weight_delta;

    modport source (output valid, result_code, weight_delta, input ready);
    modport sink   (input valid, result_code, weight_delta, output ready);
endinterface

[src/scale_frame_weight_change_decoder.sv]
// Scale frame weight-change decoder: one result per frame, one frame per cycle
// while the result receiver is ready. Path: input reg, value/scale reg, multiply
// reg, then the compare stage loads the output register.
// The compare stage holds the only state.
// Reset (sync, active low): pipeline empty, thresholds to defaults,
// stored weight and last digit bytes cleared.
`include "assert_macros.svh"

module scale_frame_weight_change_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfwc_frame_if.sink                     i_frame,
    sfwc_result_if.source                  o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfwc_pkg::PADDR_W-1:0]   paddr,
    input  logic [sfwc_pkg::PDATA_W-1:0]   pwdata,
    output logic [sfwc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import sfwc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Low address bits are byte lanes, ignored.
    // r_lo_bound = threshold - drop limit, refreshed every cycle so the
    // compare stage does a single subtract plus two compares.
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0]       r_change_threshold;
    logic [DROP_W-1:0]         r_drop_limit;
    logic signed [BOUND_W-1:0] r_lo_bound;
    logic                      w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;
    assign prdata      = (paddr[3] == REG_DROP_LIMIT)
                         ? {{(PDATA_W-DROP_W){1'b0}}, r_drop_limit}
                         : {{(PDATA_W-THRESH_W){1'b0}}, r_change_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change_threshold <= THRESH_RESET;
            r_drop_limit       <= DROP_RESET;
            r_lo_bound         <= $signed({{(BOUND_W-THRESH_W){1'b0}}, THRESH_RESET})
                                - $signed({{(BOUND_W-DROP_W){1'b0}}, DROP_RESET});
        end else begin
            if (w_cfg_write && paddr[3] == REG_CHANGE_THRESHOLD) begin
                r_change_threshold <= pwdata[THRESH_W-1:0];
            end
            if (w_cfg_write && paddr[3] == REG_DROP_LIMIT) begin
                r_drop_limit <= pwdata[DROP_W-1:0];
            end
            r_lo_bound <= $signed({{(BOUND_W-THRESH_W){1'b0}}, r_change_threshold})
                        - $signed({{(BOUND_W-DROP_W){1'b0}}, r_drop_limit});
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage moves when the one after it is empty or
    // moving, so bubbles collapse and input stays open behind a stalled
    // output register.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic w_out_free, w_c_free, w_b_free, w_a_free;

    assign w_out_free    = !r_out_valid || o_result.ready;
    assign w_c_free      = !r_c_valid || w_out_free;
    assign w_b_free      = !r_b_valid || w_c_free;
    assign w_a_free      = !r_a_valid || w_b_free;
    assign i_frame.ready = w_a_free;

    // Stage A: registered frame.
    logic [1:0]          r_a_link;
    logic [7:0]          r_a_header;
    logic [7:0]          r_a_status;
    logic [DIGITS_W-1:0] r_a_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_frame.valid) begin
            r_a_link   <= i_frame.link_status;
            r_a_header <= i_frame.header_byte;
            r_a_status <= i_frame.status_byte;
            r_a_digits <= {i_frame.digits_high_byte, i_frame.digits_mid_byte,
                           i_frame.digits_low_byte};
        end
    end

    // A -> B: link/header screening, BCD value, scale factor.
    t_result_code              n_b_code;
    logic                      n_b_frame_ok;
    logic [MAG_W-1:0]          w_mag;
    logic signed [VALUE_W-1:0] n_b_value;

    always_comb begin
        n_b_frame_ok = 1'b0;
        if (r_a_link == LINK_SHORT) begin
            n_b_code = RES_SHORT_READ;
        end else if (r_a_link != LINK_FULL) begin
            n_b_code = RES_READ_ERROR;       // includes the unused link code
        end else if (r_a_header != HEADER_VALUE) begin
            n_b_code = RES_BAD_HEADER;
        end else begin
            n_b_code     = RES_NO_CHANGE;    // settled later in the compare stage
            n_b_frame_ok = 1'b1;
        end
    end

    assign w_mag = MAG_W'(byte_digits(r_a_digits[7:0]))
                 + MAG_W'(byte_digits(r_a_digits[15:8])) * 21'd100
                 + MAG_W'(byte_digits(r_a_digits[23:16])) * 21'd10000;

    assign n_b_value = r_a_status[NEG_BIT] ? -$signed({1'b0, w_mag})
                                           :  $signed({1'b0, w_mag});

    // Stage B
    t_result_code              r_b_code;
    logic                      r_b_frame_ok;
    logic signed [VALUE_W-1:0] r_b_value;
    logic [FACTOR_W-1:0]       r_b_factor;
    logic [DIGITS_W-1:0]       r_b_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_free && r_a_valid) begin
            r_b_code     <= n_b_code;
            r_b_frame_ok <= n_b_frame_ok;
            r_b_value    <= n_b_value;
            r_b_factor   <= scale_factor(r_a_status[2:0]);
            r_b_digits   <= r_a_digits;
        end
    end

    // B -> C: signed value times scale, 22x29 bits.
    logic signed [VALUE_W+FACTOR_W:0] w_product;
    assign w_product = r_b_value * $signed({1'b0, r_b_factor});

    // Stage C
    t_result_code               r_c_code;
    logic                       r_c_frame_ok;
    logic signed [WEIGHT_W-1:0] r_c_weight;
    logic [DIGITS_W-1:0]        r_c_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_free && r_b_valid) begin
            r_c_code     <= r_b_code;
            r_c_frame_ok <= r_b_frame_ok;
            r_c_weight   <= $signed(w_product[WEIGHT_W-1:0]);
            r_c_digits   <= r_b_digits;
        end
    end

    // ------------------------------------------------------------------
    // Compare stage: repeat check against last digits, delta against the
    // stored weight. Change when delta > threshold (rise) or
    // delta <= threshold - drop limit (bag change).
    // ------------------------------------------------------------------
    logic [DIGITS_W-1:0]        r_last_digit_bytes;
    logic signed [WEIGHT_W-1:0] r_stored_weight;
    logic signed [DELTA_W-1:0]  w_delta;
    logic                       w_take, w_repeat, w_change;
    logic                       n_store_digits, n_store_weight;
    t_result_code               n_out_code;
    logic signed [DELTA_W-1:0]  n_out_delta;

    assign w_take   = r_c_valid && w_out_free;
    assign w_repeat = r_c_digits == r_last_digit_bytes;
    assign w_delta  = $signed({r_c_weight[WEIGHT_W-1], r_c_weight})
                    - $signed({r_stored_weight[WEIGHT_W-1], r_stored_weight});
    assign w_change = (w_delta > $signed({{(DELTA_W-THRESH_W){1'b0}}, r_change_threshold}))
                   || (w_delta <= $signed({{(DELTA_W-BOUND_W){r_lo_bound[BOUND_W-1]}},
                                           r_lo_bound}));

    always_comb begin
        n_out_code     = r_c_code;
        n_out_delta    = '0;
        n_store_digits = 1'b0;
        n_store_weight = 1'b0;
        if (r_c_frame_ok) begin
            if (w_repeat) begin
                n_out_code = RES_NO_CHANGE;
            end else begin
                n_store_digits = 1'b1;
                if (w_change) begin
                    n_out_code     = RES_CHANGE;
                    n_out_delta    = w_delta;
                    n_store_weight = 1'b1;
                end else begin
                    n_out_code = RES_NO_CHANGE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_digit_bytes <= '0;
            r_stored_weight    <= '0;
        end else if (w_take) begin
            if (n_store_digits) begin
                r_last_digit_bytes <= r_c_digits;
            end
            if (n_store_weight) begin
                r_stored_weight <= r_c_weight;
            end
        end
    end

    // Output register
    t_result_code              r_out_code;
    logic signed [DELTA_W-1:0] r_out_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_code  <= n_out_code;
            r_out_delta <= n_out_delta;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_code  = r_out_code;
    assign o_result.weight_delta = r_out_delta;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SFWC_ASSERT_IMPLY(a_delta_only_on_change, r_out_valid && (r_out_code != RES_CHANGE), r_out_delta == '0, "nonzero delta on a non-change result")
    `SFWC_ASSERT_IMPLY(a_weight_moves_on_change, !$stable(r_stored_weight), r_out_valid && (r_out_code == RES_CHANGE), "stored weight updated without a change result")
    `SFWC_ASSERT_IMPLY(a_digits_move_on_decode, !$stable(r_last_digit_bytes), r_out_valid && ((r_out_code == RES_CHANGE) || (r_out_code == RES_NO_CHANGE)), "last digits updated by a rejected frame")
    `SFWC_ASSERT_NEXT(a_stall_keeps_item, r_c_valid && !w_out_free, r_c_valid, "item dropped from compare stage while stalled")

endmodule

[tb/scale_frame_weight_change_decoder_tb.sv]
// Testbench for the scale frame weight-change decoder: directed frames, then random traffic.
// Checks every result against an in-bench decode model.
// Depends on sfwc_pkg, sfwc_if and the decoder RTL.
module scale_frame_weight_change_decoder_tb;
    import sfwc_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;

    // Register byte addresses (8-byte stride since drop_limit is 40 bits).
    localparam logic [PADDR_W-1:0] ADDR_CHANGE_THRESHOLD = 4'd0;
    localparam logic [PADDR_W-1:0] ADDR_DROP_LIMIT       = 4'd8;

    localparam longint unsigned THRESH_MAX = 64'd1000000000;
    localparam longint unsigned DROP_MAX   = 64'd1000000000000;

    typedef struct packed {
        logic [1:0] link;
        logic [7:0] header;
        logic [7:0] status;
        logic [7:0] lo;
        logic [7:0] mid;
        logic [7:0] hi;
    } frame_t;

    typedef struct packed {
        t_result_code              code;
        logic signed [DELTA_W-1:0] delta;
    } decode_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    sfwc_frame_if  fr ();
    sfwc_result_if rs ();

    scale_frame_weight_change_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (fr),
        .o_result(rs),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder model state, mirrors the block's registers and compare-stage state.
    logic [THRESH_W-1:0] cur_threshold;
    logic [DROP_W-1:0]   cur_drop_limit;
    logic [DIGITS_W-1:0] last_digits;
    longint              stored_weight;

    decode_t pending_results[$];

    int mismatch_count;
    int cycle_count;
    int src_idle_pct;
    int snk_idle_pct;
    bit hold_request;

    // 20-unit clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scale_frame_weight_change_decoder_tb: errors");
            $finish;
        end
    end

    function automatic longint pair_value(input logic [7:0] b);
        // Nibbles above 9 count at face value.
        return longint'(b[3:0]) + 10 * longint'(b[7:4]);
    endfunction

    // Predict one result and advance the model state.
    function automatic decode_t decode_frame(input frame_t f);
        decode_t             r;
        logic [DIGITS_W-1:0] digs;
        longint              mag;
        longint              scale;
        longint              wt;
        longint              diff;
        longint              delta;
        int                  dp;
        r.code  = RES_NO_CHANGE;
        r.delta = '0;
        if (f.link == LINK_SHORT) begin
            r.code = RES_SHORT_READ;
        end else if (f.link != LINK_FULL) begin
            // link code 3 is unused and lands here as a read error too
            r.code = RES_READ_ERROR;
        end else if (f.header != HEADER_VALUE) begin
            r.code = RES_BAD_HEADER;
        end else begin
            digs = {f.hi, f.mid, f.lo};
            if (digs != last_digits) begin
                last_digits = digs;
                mag = pair_value(f.lo) + 100 * pair_value(f.mid) + 10000 * pair_value(f.hi);
                dp = int'(f.status[2:0]);
                scale = 16;
                for (int k = dp; k < 7; k++) scale = scale * 10;
                wt = mag * scale;
                if (f.status[NEG_BIT]) wt = -wt;
                diff = wt - (stored_weight + longint'(cur_threshold));
                if (diff > 0 || diff <= -longint'(cur_drop_limit)) begin
                    delta         = wt - stored_weight;
                    stored_weight = wt;
                    r.code        = RES_CHANGE;
                    r.delta       = delta[DELTA_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic frame_t make_frame(input logic [1:0] link, input logic [7:0] header,
                                          input logic [7:0] status, input logic [7:0] lo,
                                          input logic [7:0] mid, input logic [7:0] hi);
        frame_t f;
        f.link   = link;
        f.header = header;
        f.status = status;
        f.lo     = lo;
        f.mid    = mid;
        f.hi     = hi;
        return f;
    endfunction

    // Mostly well-formed frames; some repeats, single-count nudges, link faults, bad headers.
    function automatic frame_t random_frame();
        frame_t              f;
        logic [DIGITS_W-1:0] digs;
        int                  pick;
        f.link   = LINK_FULL;
        f.header = HEADER_VALUE;
        f.status = 8'($urandom);
        digs     = 24'($urandom);
        pick     = $urandom_range(99);
        if (pick < 5) begin
            f.link = 2'($urandom_range(3, 1));
        end else if (pick < 10) begin
            f.header = 8'($urandom);
        end else if (pick < 20) begin
            digs = last_digits;
        end else if (pick < 40) begin
            // one count away from the last frame, often at the finest scale
            digs = last_digits;
            digs[3:0] = digs[3:0] + ($urandom_range(1) ? 4'd1 : 4'hF);
            if ($urandom_range(1)) f.status[2:0] = 3'd7;
        end else if (pick < 70) begin
            for (int k = 0; k < 6; k++) digs[4*k +: 4] = 4'($urandom_range(9));
        end
        {f.hi, f.mid, f.lo} = digs;
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // One frame transfer; random idle cycles ahead of it.
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < src_idle_pct) begin
            fr.valid = 1'b0;
            @(negedge i_clk);
        end
        fr.valid            = 1'b1;
        fr.link_status      = f.link;
        fr.header_byte      = f.header;
        fr.status_byte      = f.status;
        fr.digits_low_byte  = f.lo;
        fr.digits_mid_byte  = f.mid;
        fr.digits_high_byte = f.hi;
        @(posedge i_clk);
        while (!fr.ready) @(posedge i_clk);
        pending_results.push_back(decode_frame(f));
        @(negedge i_clk);
        fr.valid = 1'b0;
    endtask

    // Wait until every expected result is back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    // APB write: setup, then access; register loads at the access-cycle edge.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_CHANGE_THRESHOLD) cur_threshold = data[THRESH_W-1:0];
        else cur_drop_limit = data[DROP_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limits(input longint unsigned thr, input longint unsigned drop);
        wait_drained();
        write_reg(ADDR_CHANGE_THRESHOLD, thr);
        write_reg(ADDR_DROP_LIMIT, drop);
    endtask

    // Link faults, bad headers, the zero frame after reset and the largest frame.
    task automatic test_reset_defaults();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_frame(make_frame(2'd1, HEADER_VALUE, 8'h00, 8'h12, 8'h34, 8'h56));
        send_frame(make_frame(2'd2, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56));
        send_frame(make_frame(2'd3, HEADER_VALUE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00));
        send_frame(make_frame(LINK_FULL, 8'hFE, 8'h00, 8'h11, 8'h00, 8'h00));
        // all-zero digits match the cleared last-frame state
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Every decimal-point code, sign flipping, spare status bits set.
    task automatic test_digit_scaling();
        logic [2:0] dp;
        for (int k = 0; k < 8; k++) begin
            dp = 3'(k);
            send_frame(make_frame(LINK_FULL, HEADER_VALUE, {2'b10, dp[0], 2'b01, dp},
                                  {5'b00010, dp}, 8'h34, 8'h56));
        end
    endtask

    // Rise equal to threshold, rise past it, drop short of limit, drop reaching it.
    task automatic test_change_rule();
        set_limits(0, 0);
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h07, 8'h10, 8'h00, 8'h00));
        set_limits(16, 48);
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h07, 8'h11, 8'h00, 8'h00));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h07, 8'h12, 8'h00, 8'h00));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h07, 8'h11, 8'h00, 8'h00));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h07, 8'h10, 8'h00, 8'h00));
    endtask

    // Full-scale swings: the no-change frames in between refresh the last digits,
    // so the same full-scale digits can come back and give the widest deltas.
    task automatic test_extreme_weights();
        set_limits(THRESH_MAX, DROP_MAX);
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h20, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h20, 8'hFE, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h00, 8'hFE, 8'hFF, 8'hFF));
        send_frame(make_frame(LINK_FULL, HEADER_VALUE, 8'h20, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Random frames in four blocks, new limits before each block.
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
        longint unsigned thr;
        longint unsigned drop;
        for (int blk = 0; blk < 4; blk++) begin
            case ($urandom_range(4))
                0: thr = 0;
                1: thr = 16;
                2: thr = $urandom_range(1000000);
                3: thr = THRESH_MAX;
                default: thr = $urandom_range(32'(THRESH_MAX));
            endcase
            case ($urandom_range(4))
                0: drop = 0;
                1: drop = 48;
                2: drop = $urandom_range(100000000);
                3: drop = DROP_MAX;
                default: drop = {$urandom, $urandom} % (DROP_MAX + 1);
            endcase
            set_limits(thr, drop);
            src_idle_pct = src_pct;
            snk_idle_pct = snk_pct;
            for (int n = 0; n < count / 4; n++) send_frame(random_frame());
        end
    endtask

    // Receiver stalls for a long stretch while frames keep coming, then the
    // sender waits for the pipe to empty.
    task automatic test_backpressure();
        set_limits(100000, 80000000);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 60; n++) send_frame(random_frame());
        wait_drained();
    endtask

    // Result receiver: random stalls, plus the long hold on request.
    initial begin : result_sink
        int hold_count;
        rs.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    rs.ready = 1'b0;
                    @(negedge i_clk);
                end
                hold_request = 1'b0;
            end
            rs.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Each result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        decode_t want;
        if (i_rst_n && rs.valid && rs.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result code", longint'(rs.result_code), -1);
            end else begin
                want = pending_results.pop_front();
                if (rs.result_code !== want.code)
                    report_mismatch("result_code", longint'(rs.result_code),
                                    longint'(want.code));
                if (rs.weight_delta !== want.delta)
                    report_mismatch("weight_delta", longint'(rs.weight_delta),
                                    longint'(want.delta));
            end
        end
    end

    initial begin : main_sequence
        i_rst_n             = 1'b0;
        fr.valid            = 1'b0;
        fr.link_status      = LINK_FULL;
        fr.header_byte      = 8'h00;
        fr.status_byte      = 8'h00;
        fr.digits_low_byte  = 8'h00;
        fr.digits_mid_byte  = 8'h00;
        fr.digits_high_byte = 8'h00;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        src_idle_pct        = 0;
        snk_idle_pct        = 0;
        hold_request        = 1'b0;
        mismatch_count      = 0;
        cycle_count         = 0;
        // model reset state matches the block's
        cur_threshold       = THRESH_RESET;
        cur_drop_limit      = DROP_RESET;
        last_digits         = '0;
        stored_weight       = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_digit_scaling();
        test_change_rule();
        test_extreme_weights();
        test_random_traffic(25, 87, 560);
        test_random_traffic(87, 25, 560);
        test_random_traffic(0, 0, 560);
        test_backpressure();

        wait_drained();
        repeat (PIPE_LATENCY * 4) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("scale_frame_weight_change_decoder_tb: clean");
        end else begin
            $display("scale_frame_weight_change_decoder_tb: errors");
        end
        $finish;
    end

endmodule
